@@ rtl/core/bfse_pkg.sv @@
// Shared types, constants and helper functions for the boolean formula
// stack evaluator core. No dependencies; the evaluator core imports it.
package bfse_pkg;

    // Stack geometry
    localparam int STACK_DEPTH = 128;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int ATOM_W      = 9;
    localparam int SYM_W       = 8;

    // ASCII codes of the formula alphabet
    localparam logic [SYM_W-1:0] CH_SPACE = 8'h20;
    localparam logic [SYM_W-1:0] CH_ONE   = 8'h31;
    localparam logic [SYM_W-1:0] CH_NINE  = 8'h39;
    localparam logic [SYM_W-1:0] CH_CLOSE = 8'h29;
    localparam logic [SYM_W-1:0] CH_OPEN  = 8'h28;
    localparam logic [SYM_W-1:0] CH_NOT   = 8'h7E;
    localparam logic [SYM_W-1:0] CH_OR    = 8'h56;
    localparam logic [SYM_W-1:0] CH_AND   = 8'h5E;

    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [ADDR_W-1:0] addr_t;

    // Operator codes held on the operator stack
    typedef enum logic [2:0] {
        OP_OPEN = 3'd0,
        OP_NOT  = 3'd1,
        OP_OR   = 3'd2,
        OP_AND  = 3'd3,
        OP_IMP  = 3'd4
    } op_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_OVER  = 2'd1,
        ST_UNDER = 2'd2
    } status_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RED,
        S_APPLY,
        S_EMIT
    } state_t;

    // Decoded control for the current step of the sequencer
    typedef struct packed {
        logic    finish;
        logic    fin_truth;
        status_t fin_status;
        logic    push_val;
        logic    push_bit;
        logic    push_op;
        logic    red_start;
        logic    to_apply;
        logic    apply_bit;
    } ctl_t;

    // Map a character to its operator code
    function automatic op_t op_code(input logic [SYM_W-1:0] sym);
        op_t code;
        case (sym)
            CH_OPEN: code = OP_OPEN;
            CH_NOT:  code = OP_NOT;
            CH_OR:   code = OP_OR;
            CH_AND:  code = OP_AND;
            default: code = OP_IMP;
        endcase
        return code;
    endfunction

    // Apply one operator; a is the lower operand, b the top of stack
    function automatic logic apply_op(input op_t op, input logic a, input logic b);
        logic r;
        case (op)
            OP_NOT:  r = ~b;
            OP_OR:   r = a | b;
            OP_AND:  r = a & b;
            default: r = ~(a & ~b);
        endcase
        return r;
    endfunction

endpackage

@@ rtl/core/boolean_formula_stack_evaluator_core.sv @@
// Boolean formula evaluator: value and operator stacks in two synchronous RAMs.
// Each symbol is captured in IDLE and decoded in EXEC. A ')' runs reductions in
// RED (fetch) and APPLY (write back) until RED finds '(' or the formula ends.
// A new symbol is taken only in IDLE, once the last one is handled; a finished
// result waits in EMIT while the output register stays full.
// Reset clears counts, sequencer, output valid and atom_values; RAMs are not.
module boolean_formula_stack_evaluator_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            symbol,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  truth,
    output bfse_pkg::status_t     status,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [8:0]            cfg_data
);
    import bfse_pkg::*;

    state_t            state_reg, state_next;
    logic [SYM_W-1:0]  sym_reg, sym_next;
    logic [ATOM_W-1:0] atom_values_reg;
    cnt_t              vcnt_reg, vcnt_next;
    cnt_t              ocnt_reg, ocnt_next;
    logic              vtop_reg, vtop_next;
    op_t               otop_reg, otop_next;
    logic              res_truth_reg, res_truth_next;
    status_t           res_status_reg, res_status_next;
    logic              out_valid_reg, out_valid_next;
    logic              truth_reg, truth_next;
    status_t           status_reg, status_next;
    ctl_t              ctl;
    logic              slot_free;

    // RAM ports
    logic              vram_we, vram_re, vram_wdata, vram_rdata;
    addr_t             vram_waddr, vram_raddr;
    logic              oram_we, oram_re;
    addr_t             oram_waddr, oram_raddr;
    logic [2:0]        oram_wdata, oram_rdata;

    // Helper values
    logic              is_atom;
    logic [3:0]        atom_idx;
    logic [SYM_W-1:0]  atom_off;
    cnt_t              vcnt_m1, vcnt_m2, ocnt_m2, ocnt_m3;
    logic              lacking;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign truth     = truth_reg;
    assign status    = status_reg;
    assign slot_free = ~out_valid_reg | out_ready;

    assign is_atom  = (sym_reg >= CH_ONE) && (sym_reg <= CH_NINE);
    assign atom_off = sym_reg - CH_ONE;
    assign atom_idx = atom_off[3:0];
    assign vcnt_m1  = vcnt_reg - cnt_t'(1);
    assign vcnt_m2  = vcnt_reg - cnt_t'(2);
    assign ocnt_m2  = ocnt_reg - cnt_t'(2);
    assign ocnt_m3  = ocnt_reg - cnt_t'(3);

    // Reads into the RAMs always target entries below the cached top, and
    // writes hit the top, so a read never collides with a write in flight.
    bfse_stack_ram #(.WIDTH(1), .DEPTH(STACK_DEPTH)) u_value_ram (
        .clk   (clk),
        .we    (vram_we),
        .waddr (vram_waddr),
        .wdata (vram_wdata),
        .re    (vram_re),
        .raddr (vram_raddr),
        .rdata (vram_rdata)
    );

    bfse_stack_ram #(.WIDTH(3), .DEPTH(STACK_DEPTH)) u_op_ram (
        .clk   (clk),
        .we    (oram_we),
        .waddr (oram_waddr),
        .wdata (oram_wdata),
        .re    (oram_re),
        .raddr (oram_raddr),
        .rdata (oram_rdata)
    );

    // Decode the current step
    always_comb
    begin
        ctl     = '0;
        lacking = 1'b0;
        case (state_reg)
            S_EXEC:
            begin
                if (sym_reg == CH_SPACE)
                begin
                    ctl.finish = 1'b0;
                end
                else if (is_atom)
                begin
                    ctl.push_bit = atom_values_reg[atom_idx];
                    if (vcnt_reg == cnt_t'(STACK_DEPTH))
                    begin
                        ctl.finish     = 1'b1;
                        ctl.fin_status = ST_OVER;
                    end
                    else
                    begin
                        ctl.push_val = 1'b1;
                        if (ocnt_reg == '0)
                        begin
                            ctl.finish     = 1'b1;
                            ctl.fin_truth  = ctl.push_bit;
                            ctl.fin_status = ST_OK;
                        end
                    end
                end
                else if (sym_reg == CH_CLOSE)
                begin
                    if (ocnt_reg == '0)
                    begin
                        ctl.finish     = 1'b1;
                        ctl.fin_status = ST_UNDER;
                    end
                    else
                    begin
                        ctl.red_start = 1'b1;
                    end
                end
                else
                begin
                    if (ocnt_reg == cnt_t'(STACK_DEPTH))
                    begin
                        ctl.finish     = 1'b1;
                        ctl.fin_status = ST_OVER;
                    end
                    else
                    begin
                        ctl.push_op = 1'b1;
                    end
                end
            end
            S_RED:
            begin
                if ((ocnt_reg == '0) || (otop_reg == OP_OPEN))
                begin
                    // Loop ends; emit only if the operator stack is empty
                    if (ocnt_reg == '0)
                    begin
                        ctl.finish     = 1'b1;
                        ctl.fin_truth  = (vcnt_reg != '0) & vtop_reg;
                        ctl.fin_status = (vcnt_reg == '0) ? ST_UNDER : ST_OK;
                    end
                end
                else
                begin
                    if (otop_reg == OP_NOT)
                    begin
                        lacking = (vcnt_reg == '0);
                    end
                    else
                    begin
                        lacking = (vcnt_reg < cnt_t'(2));
                    end
                    if (lacking || (ocnt_reg < cnt_t'(2)))
                    begin
                        ctl.finish     = 1'b1;
                        ctl.fin_status = ST_UNDER;
                    end
                    else
                    begin
                        ctl.to_apply = 1'b1;
                    end
                end
            end
            S_APPLY:
            begin
                ctl.apply_bit = apply_op(otop_reg, vram_rdata, vtop_reg);
                // Both operator entries gone: the stack is empty, emit
                if (ocnt_reg == cnt_t'(2))
                begin
                    ctl.finish     = 1'b1;
                    ctl.fin_truth  = ctl.apply_bit;
                    ctl.fin_status = ST_OK;
                end
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (ctl.finish)
                begin
                    state_next = S_EMIT;
                end
                else if (ctl.red_start)
                begin
                    state_next = S_RED;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_RED:
            begin
                if (ctl.finish)
                begin
                    state_next = S_EMIT;
                end
                else if (ctl.to_apply)
                begin
                    state_next = S_APPLY;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_APPLY:
            begin
                state_next = ctl.finish ? S_EMIT : S_RED;
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath, RAM controls and output register
    always_comb
    begin
        sym_next        = sym_reg;
        vcnt_next       = vcnt_reg;
        ocnt_next       = ocnt_reg;
        vtop_next       = vtop_reg;
        otop_next       = otop_reg;
        res_truth_next  = res_truth_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        truth_next      = truth_reg;
        status_next     = status_reg;
        vram_we         = 1'b0;
        vram_waddr      = vcnt_reg[ADDR_W-1:0];
        vram_wdata      = ctl.push_bit;
        vram_re         = 1'b0;
        vram_raddr      = vcnt_m2[ADDR_W-1:0];
        oram_we         = 1'b0;
        oram_waddr      = ocnt_reg[ADDR_W-1:0];
        oram_wdata      = op_code(sym_reg);
        oram_re         = 1'b0;
        oram_raddr      = ocnt_m3[ADDR_W-1:0];

        // Drop a delivered result
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    sym_next = symbol;
                end
            end
            S_EXEC:
            begin
                // Push an atom value
                if (ctl.push_val)
                begin
                    vram_we   = 1'b1;
                    vtop_next = ctl.push_bit;
                    vcnt_next = vcnt_reg + cnt_t'(1);
                end
                // Push an operator
                if (ctl.push_op)
                begin
                    oram_we   = 1'b1;
                    otop_next = op_code(sym_reg);
                    ocnt_next = ocnt_reg + cnt_t'(1);
                end
            end
            S_RED:
            begin
                // Fetch the lower operand and the operator below the dropped one
                if (ctl.to_apply)
                begin
                    vram_re = 1'b1;
                    oram_re = 1'b1;
                end
            end
            S_APPLY:
            begin
                // Replace operands by the result, drop two operator entries
                vram_we    = 1'b1;
                vram_wdata = ctl.apply_bit;
                vtop_next  = ctl.apply_bit;
                ocnt_next  = ocnt_m2;
                otop_next  = op_t'(oram_rdata);
                if (otop_reg == OP_NOT)
                begin
                    vram_waddr = vcnt_m1[ADDR_W-1:0];
                end
                else
                begin
                    vram_waddr = vcnt_m2[ADDR_W-1:0];
                    vcnt_next  = vcnt_m1;
                end
            end
            S_EMIT:
            begin
                // Hand the pending result to the output register
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    truth_next     = res_truth_reg;
                    status_next    = res_status_reg;
                end
            end
            default:
            begin
                sym_next = sym_reg;
            end
        endcase

        // Hold the result and clear both stacks
        if (ctl.finish)
        begin
            res_truth_next  = ctl.fin_truth;
            res_status_next = ctl.fin_status;
            vcnt_next       = '0;
            ocnt_next       = '0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            vcnt_reg        <= '0;
            ocnt_reg        <= '0;
            out_valid_reg   <= 1'b0;
            atom_values_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            vcnt_reg      <= vcnt_next;
            ocnt_reg      <= ocnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                atom_values_reg <= cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        sym_reg        <= sym_next;
        vtop_reg       <= vtop_next;
        otop_reg       <= otop_next;
        res_truth_reg  <= res_truth_next;
        res_status_reg <= res_status_next;
        truth_reg      <= truth_next;
        status_reg     <= status_next;
    end

endmodule

@@ rtl/core/bfse_stack_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// Used for both evaluator stacks; no package dependency.
module bfse_stack_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ tb/formula_result_checker.sv @@
`timescale 1ns / 100ps
// Result checker for the boolean formula stack evaluator core: predicts every
// result from the accepted symbols and atom settings. Depends on bfse_pkg.
module formula_result_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [7:0]        symbol,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic              truth,
    input  bfse_pkg::status_t status,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [8:0]        cfg_data,
    input  logic              wrap_up,
    output int                fail_count,
    output int                pending,
    output int                predicted_ops,
    output int                results_seen
);
    import bfse_pkg::*;

    typedef struct packed {
        logic    truth;
        status_t status;
    } formula_result_t;

    // Predicted stack contents and register copy
    logic            bit_stack [STACK_DEPTH];
    op_t             op_stack  [STACK_DEPTH];
    int              bit_count;
    int              op_count;
    logic [8:0]      atom_truths;

    formula_result_t awaited_results[$];
    int              errors;
    int              checked;
    bit              wrapped;

    function automatic void note_failure(string msg);
        errors++;
        if (errors <= 10)
            $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    // Queue a result and empty both stacks
    function automatic void close_formula(logic t, status_t s);
        formula_result_t r;
        r.truth  = t;
        r.status = s;
        awaited_results.push_back(r);
        bit_count = 0;
        op_count  = 0;
    endfunction

    function automatic op_t symbol_to_op(logic [7:0] s);
        if (s == CH_OPEN) return OP_OPEN;
        if (s == CH_NOT)  return OP_NOT;
        if (s == CH_OR)   return OP_OR;
        if (s == CH_AND)  return OP_AND;
        return OP_IMP;
    endfunction

    // Advance the predicted stacks by one symbol
    function automatic void evaluate_symbol(logic [7:0] s);
        op_t  top_op;
        logic lhs;
        logic rhs;
        if (s == CH_SPACE)
            return;
        if (s >= CH_ONE && s <= CH_NINE)
        begin
            if (bit_count >= STACK_DEPTH)
            begin
                close_formula(1'b0, ST_OVER);
                return;
            end
            bit_stack[bit_count] = atom_truths[s - CH_ONE];
            bit_count++;
        end
        else if (s != CH_CLOSE)
        begin
            if (op_count >= STACK_DEPTH)
            begin
                close_formula(1'b0, ST_OVER);
                return;
            end
            op_stack[op_count] = symbol_to_op(s);
            op_count++;
        end
        else
        begin
            if (op_count == 0)
            begin
                close_formula(1'b0, ST_UNDER);
                return;
            end
            // Reduce until an open parenthesis is on top
            while (op_count > 0 && op_stack[op_count-1] != OP_OPEN)
            begin
                top_op = op_stack[op_count-1];
                if (top_op == OP_NOT)
                begin
                    if (bit_count < 1)
                    begin
                        close_formula(1'b0, ST_UNDER);
                        return;
                    end
                    bit_stack[bit_count-1] = ~bit_stack[bit_count-1];
                    op_count--;
                end
                else
                begin
                    if (bit_count < 2)
                    begin
                        close_formula(1'b0, ST_UNDER);
                        return;
                    end
                    rhs = bit_stack[bit_count-1];
                    lhs = bit_stack[bit_count-2];
                    op_count--;
                    bit_count--;
                    case (top_op)
                        OP_OR:   bit_stack[bit_count-1] = lhs | rhs;
                        OP_AND:  bit_stack[bit_count-1] = lhs & rhs;
                        default: bit_stack[bit_count-1] = (lhs && !rhs) ? 1'b0 : 1'b1;
                    endcase
                end
                // Drop the operator below the one just applied
                if (op_count == 0)
                begin
                    close_formula(1'b0, ST_UNDER);
                    return;
                end
                op_count--;
            end
        end
        if (op_count == 0)
        begin
            if (bit_count == 0)
                close_formula(1'b0, ST_UNDER);
            else
                close_formula(bit_stack[bit_count-1], ST_OK);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        formula_result_t exp_r;
        if (!rst_n)
        begin
            bit_count   = 0;
            op_count    = 0;
            atom_truths = '0;
            errors      = 0;
            checked     = 0;
            wrapped     = 1'b0;
            awaited_results.delete();
        end
        else
        begin
            // Compare the result leaving the block
            if (out_valid && out_ready)
            begin
                checked++;
                if (awaited_results.size() == 0)
                begin
                    note_failure($sformatf("unexpected result truth=%0b status=%0d",
                                           truth, status));
                end
                else
                begin
                    exp_r = awaited_results.pop_front();
                    if (truth !== exp_r.truth || status !== exp_r.status)
                        note_failure($sformatf(
                            "expected truth=%0b status=%0d, got truth=%0b status=%0d",
                            exp_r.truth, exp_r.status, truth, status));
                end
            end
            if (cfg_valid && cfg_ready)
                atom_truths = cfg_data;
            if (in_valid && in_ready)
                evaluate_symbol(symbol);
            // Leftover expectations at the end of the run
            if (wrap_up && !wrapped)
            begin
                wrapped = 1'b1;
                if (awaited_results.size() != 0)
                    note_failure($sformatf("%0d results never arrived",
                                           awaited_results.size()));
            end
        end
        fail_count    <= errors;
        pending       <= awaited_results.size();
        predicted_ops <= op_count;
        results_seen  <= checked;
    end

endmodule

@@ tb/tb_boolean_formula_stack_evaluator_core.sv @@
`timescale 1ns / 100ps
// Top of the evaluator regression: clock, reset, formula stimulus, output
// back-pressure and verdict. Depends on bfse_pkg, the core and the checker.
module tb_boolean_formula_stack_evaluator_core;
    import bfse_pkg::*;

    localparam int STALL_LIMIT     = 20000;
    localparam int SETTLE_CYCLES   = 300;
    localparam int LONG_HOLD       = 1500;
    localparam int RANDOM_PHASES   = 6;
    localparam int ITEMS_PER_PHASE = 250;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] symbol;
    logic       out_valid;
    logic       out_ready;
    logic       truth;
    status_t    status;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [8:0] cfg_data;
    logic       wrap_up;

    int fail_count;
    int pending;
    int predicted_ops;
    int results_seen;

    // Stimulus bookkeeping
    logic [7:0] text_q[$];
    bit         calm_sender;
    int         symbols_sent;
    int         formulas_sent;
    int         rough_runs;
    int         settings_applied;
    int         hold_request;

    boolean_formula_stack_evaluator_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .symbol    (symbol),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .truth     (truth),
        .status    (status),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    formula_result_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .symbol        (symbol),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .truth         (truth),
        .status        (status),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .wrap_up       (wrap_up),
        .fail_count    (fail_count),
        .pending       (pending),
        .predicted_ops (predicted_ops),
        .results_seen  (results_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Formula text generation
    function automatic void put_char(logic [7:0] c);
        if ($urandom_range(0, 9) == 0)
            text_q.push_back(CH_SPACE);
        text_q.push_back(c);
    endfunction

    function automatic logic [7:0] any_digit();
        return CH_ONE + 8'($urandom_range(0, 8));
    endfunction

    // OR, AND, or any other byte, which evaluates as implication
    function automatic logic [7:0] pick_binop();
        logic [7:0] c;
        int         r;
        r = $urandom_range(0, 9);
        if (r < 4) return CH_OR;
        if (r < 7) return CH_AND;
        do
            c = 8'($urandom_range(0, 255));
        while (c == CH_SPACE || c == CH_OPEN || c == CH_CLOSE || c == CH_NOT ||
               c == CH_OR || c == CH_AND || (c >= CH_ONE && c <= CH_NINE));
        return c;
    endfunction

    // A compound right operand closes its parent through the cascade, so the
    // parent's own closing parenthesis is written only after an atom.
    function automatic void put_compound(int depth);
        bit right_atom;
        put_char(CH_OPEN);
        if ($urandom_range(0, 3) == 0)
        begin
            put_char(CH_NOT);
        end
        else
        begin
            put_formula(depth - 1);
            put_char(pick_binop());
        end
        right_atom = (depth <= 1) || ($urandom_range(0, 1) == 0);
        if (right_atom)
        begin
            put_char(any_digit());
            put_char(CH_CLOSE);
        end
        else
        begin
            put_compound(depth - 1);
        end
    endfunction

    function automatic void put_formula(int depth);
        if (depth == 0 || $urandom_range(0, 2) == 0)
            put_char(any_digit());
        else
            put_compound(depth);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm_sender || r < 75) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one request and hold it until accepted
    task automatic send_sym(input logic [7:0] s);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        symbol   <= s;
        do @(posedge clk); while (!in_ready);
        if (s != CH_SPACE)
            symbols_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_sym(s[i]);
    endtask

    task automatic send_queue();
        foreach (text_q[i])
            send_sym(text_q[i]);
        text_q.delete();
    endtask

    task automatic park_input();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // Drive leftover operators off the stack so later formulas start clean
    task automatic flush_stacks();
        park_input();
        while (predicted_ops != 0)
        begin
            send_text("1V1)");
            park_input();
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_atoms(input logic [8:0] v);
        park_input();
        wait_drained();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        settings_applied++;
    endtask

    // One random job: a clean formula, a damaged one, or plain noise
    task automatic run_random_job();
        int r;
        int pos;
        int depth;
        r = $urandom_range(0, 99);
        calm_sender = ($urandom_range(0, 3) == 0);
        depth = ($urandom_range(0, 19) == 0) ? 7 : $urandom_range(0, 5);
        if (r < 70)
        begin
            put_formula(depth);
            send_queue();
            formulas_sent++;
        end
        else if (r < 85)
        begin
            put_formula($urandom_range(1, 4));
            pos = $urandom_range(0, text_q.size() - 1);
            case ($urandom_range(0, 3))
                0:       while (text_q.size() > pos) void'(text_q.pop_back());
                1:       text_q[pos] = 8'($urandom_range(0, 255));
                2:       text_q.push_back(CH_CLOSE);
                default: text_q.insert(pos, CH_OPEN);
            endcase
            send_queue();
            flush_stacks();
            rough_runs++;
        end
        else
        begin
            repeat ($urandom_range(1, 8))
                text_q.push_back(8'($urandom_range(0, 255)));
            send_queue();
            flush_stacks();
            rough_runs++;
        end
    endtask

    // Output back-pressure: short and long stalls, calm stretches, long hold
    initial
    begin
        int  stall_left;
        int  hold_seen;
        int  tick;
        bit  rx_calm;
        int  r;
        stall_left = 0;
        hold_seen  = 0;
        tick       = 0;
        rx_calm    = 1'b0;
        out_ready  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            tick++;
            if (tick % 400 == 0)
                rx_calm = ($urandom_range(0, 2) == 0);
            if (hold_request != hold_seen)
            begin
                hold_seen = hold_request;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            else if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                r = $urandom_range(0, 99);
                if (!rx_calm && r >= 70)
                    stall_left = (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 60);
            end
        end
    end

    // End the run if nothing moves for too long
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        logic [8:0] setting;
        int         phase_start;
        in_valid         = 1'b0;
        symbol           = '0;
        cfg_valid        = 1'b0;
        cfg_data         = '0;
        wrap_up          = 1'b0;
        calm_sender      = 1'b0;
        symbols_sent     = 0;
        formulas_sent    = 0;
        rough_runs       = 0;
        settings_applied = 0;
        hold_request     = 0;
        rst_n            = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: a lone atom, each operator, and the malformed cases
        apply_atoms(9'h169);
        send_text("1");
        send_text(")");
        send_text("(2 V3)");
        send_text("(9^4)");
        send_text("(~5)");
        send_text("(1");
        send_sym(8'hFF);
        send_text("2)");
        send_text("(~)");
        send_text("(");
        send_sym(8'h00);
        send_text("1)");
        send_text("~1)");

        // Fill each stack past its depth, input stalling under pressure
        apply_atoms(9'h0F0);
        calm_sender = 1'b1;
        send_text("(");
        repeat (STACK_DEPTH + 1) send_sym(any_digit());
        repeat (STACK_DEPTH + 1) send_sym(CH_OPEN);

        // Random phases over several atom settings
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0:       setting = 9'h000;
                1:       setting = 9'h1FF;
                default: setting = 9'($urandom_range(0, 511));
            endcase
            apply_atoms(setting);
            if (p == 2)
                hold_request++;
            phase_start = symbols_sent;
            while (symbols_sent - phase_start < ITEMS_PER_PHASE)
                run_random_job();
        end

        // Drain and report
        park_input();
        wait_drained();
        @(negedge clk);
        wrap_up <= 1'b1;
        @(posedge clk);
        @(negedge clk);
        $display("Sent %0d symbols: %0d clean formulas, %0d noisy or damaged runs,",
                 symbols_sent, formulas_sent, rough_runs);
        $display("%0d settings; checked %0d results, including both stack overflows.",
                 settings_applied, results_seen);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
